// ----- src/bpu_pkg.sv -----
package bpu_pkg;

   localparam int MAX_DIMENSION = 4096;
   localparam int DIM_W         = $clog2(MAX_DIMENSION) + 1;
   localparam int POS_W         = $clog2(MAX_DIMENSION);
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 32;
   localparam int NUM_CHANNELS  = 4;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int QUOT_W        = 8;
   localparam int REM_W         = 32 + QUOT_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOTTOM_UP    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIXEL_FORMAT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_RED_MASK     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_GREEN_MASK   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLUE_MASK    = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA_MASK   = 3'd7;

   localparam logic [1:0] FMT_BGR24  = 2'd0;
   localparam logic [1:0] FMT_BGRA32 = 2'd1;

   localparam int CH_RED   = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 2;
   localparam int CH_ALPHA = 3;

   localparam logic [31:0] RESET_RED_MASK   = 32'h00FF_0000;
   localparam logic [31:0] RESET_GREEN_MASK = 32'h0000_FF00;
   localparam logic [31:0] RESET_BLUE_MASK  = 32'h0000_00FF;
   localparam logic [31:0] RESET_ALPHA_MASK = 32'h0000_0000;
   localparam logic [7:0]  CHANNEL_FULL     = 8'd255;

   typedef struct packed {
      logic [DIM_W-1:0]                   image_width;
      logic [DIM_W-1:0]                   image_height;
      logic                               bottom_up;
      logic [1:0]                         pixel_format;
      logic [NUM_CHANNELS-1:0][31:0]      field_mask;
   } cfg_type;

   typedef struct packed {
      logic [31:0]      pixel;
      logic [POS_W-1:0] column;
      logic [POS_W-1:0] row;
      logic             last_pixel;
   } pix_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0)
         r = DIM_W'(1);
      else if (v > DIM_W'(MAX_DIMENSION))
         r = DIM_W'(MAX_DIMENSION);
      return r;
   endfunction

endpackage

// ----- src/bpu_front.sv -----
module bpu_front import bpu_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   input  logic                 req_push,
   input  logic [7:0]           req_data_byte,
   input  logic                 queue_full,
   output logic                 queue_push,
   output pix_type              queue_data
);

   logic [23:0]      acc_ff, acc_in;
   logic [1:0]       bip_ff, bip_in;
   logic [POS_W-1:0] col_ff, col_in;
   logic [POS_W-1:0] row_ff, row_in;
   logic [1:0]       pad_ff, pad_in;

   logic             accept;
   logic             is_bgr24;
   logic [1:0]       bip_top;
   logic [DIM_W-1:0] w, h;
   logic [DIM_W-1:0] col_next, row_next, flip_row;
   logic             last_col, last_row;
   logic [1:0]       w_bytes_low;
   logic [31:0]      pixel;

   always_comb begin
      accept      = req_push && !queue_full;
      is_bgr24    = (cfg.pixel_format == FMT_BGR24);
      bip_top     = is_bgr24 ? 2'd2 : 2'd3;
      w           = clamp_dim(cfg.image_width);
      h           = clamp_dim(cfg.image_height);
      col_next    = {1'b0, col_ff} + DIM_W'(1);
      row_next    = {1'b0, row_ff} + DIM_W'(1);
      last_col    = col_next >= w;
      last_row    = row_next >= h;
      flip_row    = h - DIM_W'(1) - {1'b0, row_ff};
      w_bytes_low = w[1:0] + {w[0], 1'b0};
      pixel       = is_bgr24 ? {8'h00, req_data_byte, acc_ff[15:0]}
                             : {req_data_byte, acc_ff};

      acc_in     = acc_ff;
      bip_in     = bip_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      pad_in     = pad_ff;
      queue_push = 1'b0;

      queue_data.pixel      = pixel;
      queue_data.column     = col_ff;
      queue_data.row        = cfg.bottom_up ? flip_row[POS_W-1:0] : row_ff;
      queue_data.last_pixel = last_col && last_row;

      if (accept) begin
         if (pad_ff != 2'd0) begin
            pad_in = pad_ff - 2'd1;
         end else if (bip_ff < bip_top) begin
            unique case (bip_ff)
               2'd0:    acc_in = {acc_ff[23:8], req_data_byte};
               2'd1:    acc_in = {acc_ff[23:16], req_data_byte, acc_ff[7:0]};
               default: acc_in = {req_data_byte, acc_ff[15:0]};
            endcase
            bip_in = bip_ff + 2'd1;
         end else begin
            queue_push = 1'b1;
            acc_in     = '0;
            bip_in     = '0;
            if (last_col) begin
               col_in = '0;
               pad_in = is_bgr24 ? (2'd0 - w_bytes_low) : 2'd0;
               row_in = last_row ? '0 : row_next[POS_W-1:0];
            end else begin
               col_in = col_next[POS_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         bip_ff <= '0;
         col_ff <= '0;
         row_ff <= '0;
         pad_ff <= '0;
      end else begin
         acc_ff <= acc_in;
         bip_ff <= bip_in;
         col_ff <= col_in;
         row_ff <= row_in;
         pad_ff <= pad_in;
      end
   end

endmodule

// ----- src/bpu_queue.sv -----
module bpu_queue import bpu_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  pix_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output pix_type pop_data
);

   pix_type                mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ff, wr_in;
   logic [QUEUE_PTR_W-1:0] rd_ff, rd_in;
   logic [QUEUE_CNT_W-1:0] cnt_ff, cnt_in;
   logic                   do_push, do_pop;

   always_comb begin
      full     = (cnt_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
      empty    = (cnt_ff == '0);
      pop_data = mem_ff[rd_ff];
      do_push  = push && !full;
      do_pop   = pop && !empty;
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      if (do_push)
         wr_in = (wr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + QUEUE_PTR_W'(1);
      if (do_pop)
         rd_in = (rd_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + QUEUE_PTR_W'(1);
      cnt_in = cnt_ff + QUEUE_CNT_W'(do_push) - QUEUE_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push)
         mem_ff[wr_ff] <= push_data;
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ----- src/bpu_back.sv -----
module bpu_back import bpu_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             queue_empty,
   input  pix_type          queue_data,
   output logic             queue_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic [31:0]      rsp_rgba_word,
   output logic [POS_W-1:0] rsp_dest_column,
   output logic [POS_W-1:0] rsp_dest_row,
   output logic             rsp_final_pixel
);

   typedef enum logic [1:0] {IDLE, DIVIDE, DONE} state_type;

   state_type                          state_ff, state_in;
   logic [NUM_CHANNELS-1:0][REM_W-1:0] rem_ff, rem_in;
   logic [NUM_CHANNELS-1:0][REM_W-1:0] div_ff, div_in;
   logic [NUM_CHANNELS-1:0][QUOT_W-1:0] quo_ff, quo_in;
   logic [2:0]                         step_ff, step_in;
   logic [POS_W-1:0]                   col_ff, col_in;
   logic [POS_W-1:0]                   row_ff, row_in;
   logic                               last_ff, last_in;
   logic                               out_valid_ff, out_valid_in;
   logic [31:0]                        out_word_ff, out_word_in;
   logic [POS_W-1:0]                   out_col_ff, out_col_in;
   logic [POS_W-1:0]                   out_row_ff, out_row_in;
   logic                               out_last_ff, out_last_in;

   logic                               out_free;
   logic [31:0]                        pm;
   logic [NUM_CHANNELS-1:0][7:0]       chan;
   logic [31:0]                        px;

   always_comb begin
      out_free     = !out_valid_ff || rsp_pop;
      queue_pop    = 1'b0;
      px           = queue_data.pixel;
      pm           = '0;
      chan         = '0;
      state_in     = state_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      last_in      = last_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_word_in  = out_word_ff;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      out_last_in  = out_last_ff;

      unique case (state_ff)
         IDLE: begin
            if (!queue_empty && out_free) begin
               queue_pop = 1'b1;
               if (cfg.pixel_format == FMT_BGR24 || cfg.pixel_format == FMT_BGRA32) begin
                  out_valid_in = 1'b1;
                  out_word_in  = {(cfg.pixel_format == FMT_BGR24) ? CHANNEL_FULL : px[31:24],
                                  px[7:0], px[15:8], px[23:16]};
                  out_col_in   = queue_data.column;
                  out_row_in   = queue_data.row;
                  out_last_in  = queue_data.last_pixel;
               end else begin
                  // field value over mask equals the shifted ratio, so skip the shift
                  for (int c = 0; c < NUM_CHANNELS; c++) begin
                     pm        = px & cfg.field_mask[c];
                     rem_in[c] = {pm, 8'h00} - {8'h00, pm};
                     div_in[c] = {1'b0, cfg.field_mask[c], 7'h00};
                     quo_in[c] = '0;
                  end
                  step_in  = '0;
                  col_in   = queue_data.column;
                  row_in   = queue_data.row;
                  last_in  = queue_data.last_pixel;
                  state_in = DIVIDE;
               end
            end
         end
         DIVIDE: begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
               if (rem_ff[c] >= div_ff[c]) begin
                  rem_in[c] = rem_ff[c] - div_ff[c];
                  quo_in[c] = {quo_ff[c][QUOT_W-2:0], 1'b1};
               end else begin
                  quo_in[c] = {quo_ff[c][QUOT_W-2:0], 1'b0};
               end
               div_in[c] = {1'b0, div_ff[c][REM_W-1:1]};
            end
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd7)
               state_in = DONE;
         end
         DONE: begin
            if (out_free) begin
               for (int c = 0; c < NUM_CHANNELS; c++)
                  chan[c] = (cfg.field_mask[c] == '0) ? CHANNEL_FULL : quo_ff[c];
               out_valid_in = 1'b1;
               out_word_in  = {chan[CH_ALPHA], chan[CH_BLUE], chan[CH_GREEN], chan[CH_RED]};
               out_col_in   = col_ff;
               out_row_in   = row_ff;
               out_last_in  = last_ff;
               state_in     = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      quo_ff      <= quo_in;
      step_ff     <= step_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      last_ff     <= last_in;
      out_word_ff <= out_word_in;
      out_col_ff  <= out_col_in;
      out_row_ff  <= out_row_in;
      out_last_ff <= out_last_in;
      if (reset) begin
         state_ff     <= IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_empty       = !out_valid_ff;
   assign rsp_rgba_word   = out_word_ff;
   assign rsp_dest_column = out_col_ff;
   assign rsp_dest_row    = out_row_ff;
   assign rsp_final_pixel = out_last_ff;

endmodule

// ----- src/bmp_pixel_unpacker.sv -----
// BMP pixel array to ABGR8888. Feed the pixel array one byte per beat, padding
// included; one result beat leaves per pixel with its column, top-down row and
// a mark on the last pixel of the image. The front end takes a byte every cycle
// while its two-pixel queue has room, so 24-bit pixels arrive every three bytes
// and 32-bit pixels every four. The back end converts a 24-bit or direct 32-bit
// pixel as it pops it from the queue; a masked pixel goes through load, eight
// restoring division steps for the four channels in parallel, and output, and
// that divider sets the sustained rate in masked mode. Write configuration only
// while the block is idle; no clearing pass is needed after reset.
module bmp_pixel_unpacker import bpu_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [7:0]             req_data_byte,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [31:0]            rsp_rgba_word,
   output logic [POS_W-1:0]       rsp_dest_column,
   output logic [POS_W-1:0]       rsp_dest_row,
   output logic                   rsp_final_pixel,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   cfg_type cfg_ff, cfg_in;
   logic    queue_push, queue_pop, queue_full, queue_empty;
   pix_type push_data, pop_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  cfg_in.image_width  = csr_write_data[DIM_W-1:0];
            CSR_IMAGE_HEIGHT: cfg_in.image_height = csr_write_data[DIM_W-1:0];
            CSR_BOTTOM_UP:    cfg_in.bottom_up    = csr_write_data[0];
            CSR_PIXEL_FORMAT: cfg_in.pixel_format = csr_write_data[1:0];
            CSR_RED_MASK:     cfg_in.field_mask[CH_RED]   = csr_write_data;
            CSR_GREEN_MASK:   cfg_in.field_mask[CH_GREEN] = csr_write_data;
            CSR_BLUE_MASK:    cfg_in.field_mask[CH_BLUE]  = csr_write_data;
            CSR_ALPHA_MASK:   cfg_in.field_mask[CH_ALPHA] = csr_write_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width          <= DIM_W'(1);
         cfg_ff.image_height         <= DIM_W'(1);
         cfg_ff.bottom_up            <= 1'b1;
         cfg_ff.pixel_format         <= FMT_BGR24;
         cfg_ff.field_mask[CH_RED]   <= RESET_RED_MASK;
         cfg_ff.field_mask[CH_GREEN] <= RESET_GREEN_MASK;
         cfg_ff.field_mask[CH_BLUE]  <= RESET_BLUE_MASK;
         cfg_ff.field_mask[CH_ALPHA] <= RESET_ALPHA_MASK;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_full = queue_full;

   bpu_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .req_push      (req_push),
      .req_data_byte (req_data_byte),
      .queue_full    (queue_full),
      .queue_push    (queue_push),
      .queue_data    (push_data)
   );

   bpu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (queue_pop),
      .empty     (queue_empty),
      .pop_data  (pop_data)
   );

   bpu_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .queue_empty     (queue_empty),
      .queue_data      (pop_data),
      .queue_pop       (queue_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_rgba_word   (rsp_rgba_word),
      .rsp_dest_column (rsp_dest_column),
      .rsp_dest_row    (rsp_dest_row),
      .rsp_final_pixel (rsp_final_pixel)
   );

endmodule
